>>> sv/hmm_viterbi_step_assert.svh
// ----------------------------------------------------------------------------
// hmm_viterbi_step_assert.svh
// Assertion macros used by the HMM Viterbi step checker.
// ----------------------------------------------------------------------------
`ifndef HMM_VITERBI_STEP_ASSERT_SVH
`define HMM_VITERBI_STEP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define HMMV_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hmm_viterbi_step: same-cycle check failed");

// Antecedent implies consequent in the following cycle.
`define HMMV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hmm_viterbi_step: next-cycle check failed");

`endif

>>> sv/hmmv_pkg.sv
// ----------------------------------------------------------------------------
// hmmv_pkg
// Shared types and constants of the 3-state HMM Viterbi step block.
// ----------------------------------------------------------------------------
package hmmv_pkg;

  localparam int NUM_STATES     = 3;
  localparam int STATE_W        = 2;
  localparam int OUT_SCORE_BITS = 32;
  localparam int CFG_BITS       = 48;
  localparam int CFG_IDX_BITS   = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TRANS0  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TRANS1  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TRANS2  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_EMIT0   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_EMIT1   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_EMIT2   = 3'd6;

  // Observation symbols; the fourth code has no meaning and emits nothing.
  localparam logic [1:0] SYM_UP   = 2'd0;
  localparam logic [1:0] SYM_DOWN = 2'd1;
  localparam logic [1:0] SYM_FLAT = 2'd2;
  localparam logic [1:0] SYM_NONE = 2'd3;

  typedef logic [STATE_W-1:0] state_idx_t;

  typedef struct packed {
    logic [1:0] observation;
    logic       first_of_sequence;
  } hmmv_in_t;

  typedef struct packed {
    state_idx_t                best_state;
    logic [OUT_SCORE_BITS-1:0] best_score;
    state_idx_t                back_from_s0;
    state_idx_t                back_from_s1;
    state_idx_t                back_from_s2;
  } hmmv_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the input beat
    logic mul;    // form score times transition products, or initial times emission on a start
    logic emit;   // pick predecessors, multiply by emission, or pass a start through
    logic fin;    // commit scores and load the result register
  } hmmv_cmd_t;

endpackage

>>> sv/hmmv_ctrl.sv
// ----------------------------------------------------------------------------
// hmmv_ctrl
// Sequencer of the Viterbi step: walks one item through the datapath stages
// and owns the handshake flags of both channels.
// ----------------------------------------------------------------------------
module hmmv_ctrl
  import hmmv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output hmmv_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  assign cmd.load = in_valid && in_ready;
  assign cmd.mul  = (state == ST_MUL);
  assign cmd.emit = (state == ST_EMIT);
  assign cmd.fin  = (state == ST_FIN) && out_free;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_MUL;
      ST_MUL:  state_next = ST_EMIT;
      ST_EMIT: state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // State and result-valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/hmmv_datapath.sv
// ----------------------------------------------------------------------------
// hmmv_datapath
// Configuration registers, path scores, the nine product lanes, predecessor
// selection, emission scaling and the result register.
// ----------------------------------------------------------------------------
module hmmv_datapath
  import hmmv_pkg::*;
#(
  parameter int PROB_BITS  = 16,
  parameter int SCORE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  hmmv_cmd_t               cmd,
  input  hmmv_in_t                in_data,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  output hmmv_out_t               out_data
);

  localparam int PACK_BITS  = NUM_STATES * PROB_BITS;
  localparam int PROD_BITS  = SCORE_BITS + PROB_BITS;
  localparam int FIRST_BITS = 2 * PROB_BITS;
  localparam int FIRST_SHR  = (FIRST_BITS >= SCORE_BITS) ? FIRST_BITS - SCORE_BITS : 0;
  localparam int FIRST_SHL  = (FIRST_BITS >= SCORE_BITS) ? 0 : SCORE_BITS - FIRST_BITS;

  logic [PACK_BITS-1:0]                   init_probs;
  logic [NUM_STATES-1:0][PACK_BITS-1:0]   trans_rows;
  logic [NUM_STATES-1:0][PACK_BITS-1:0]   emit_rows;
  logic [NUM_STATES-1:0][SCORE_BITS-1:0]  path_scores;
  logic [1:0]                             sym;
  logic                                   first_q;

  logic [NUM_STATES-1:0][PROB_BITS-1:0]   em;
  logic [NUM_STATES-1:0][NUM_STATES-1:0][PROD_BITS-1:0] mul_a;
  logic [NUM_STATES-1:0][NUM_STATES-1:0][PROD_BITS-1:0] mul_b;
  logic [NUM_STATES-1:0][NUM_STATES-1:0][PROD_BITS-1:0] prod;
  logic [NUM_STATES-1:0][SCORE_BITS-1:0]  top;
  logic [NUM_STATES-1:0]                  [STATE_W-1:0] arg;
  logic [NUM_STATES-1:0][PROD_BITS-1:0]   eprod;
  logic [NUM_STATES-1:0][STATE_W-1:0]     back;
  logic [NUM_STATES-1:0][SCORE_BITS-1:0]  new_score;
  logic [SCORE_BITS-1:0]                  best_val;
  state_idx_t                             best_idx;

  // Configuration writes; indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_probs <= '0;
      trans_rows <= '0;
      emit_rows  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_INITIAL: init_probs    <= cfg_data[PACK_BITS-1:0];
        REG_TRANS0:  trans_rows[0] <= cfg_data[PACK_BITS-1:0];
        REG_TRANS1:  trans_rows[1] <= cfg_data[PACK_BITS-1:0];
        REG_TRANS2:  trans_rows[2] <= cfg_data[PACK_BITS-1:0];
        REG_EMIT0:   emit_rows[0]  <= cfg_data[PACK_BITS-1:0];
        REG_EMIT1:   emit_rows[1]  <= cfg_data[PACK_BITS-1:0];
        REG_EMIT2:   emit_rows[2]  <= cfg_data[PACK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym     <= in_data.observation;
      first_q <= in_data.first_of_sequence;
    end
  end

  // Emission probability of the current symbol in each state.
  always_comb begin
    for (int j = 0; j < NUM_STATES; j++) begin
      case (sym)
        SYM_UP:   em[j] = emit_rows[j][0 +: PROB_BITS];
        SYM_DOWN: em[j] = emit_rows[j][PROB_BITS +: PROB_BITS];
        SYM_FLAT: em[j] = emit_rows[j][2*PROB_BITS +: PROB_BITS];
        default:  em[j] = '0;
      endcase
    end
  end

  // Operands of the product lanes. Lane (i, j) is predecessor i into state j;
  // a sequence start uses lane (0, j) for initial times emission.
  always_comb begin
    for (int i = 0; i < NUM_STATES; i++) begin
      for (int j = 0; j < NUM_STATES; j++) begin
        if (first_q) begin
          mul_a[i][j] = (i == 0) ? PROD_BITS'(init_probs[j*PROB_BITS +: PROB_BITS]) : '0;
          mul_b[i][j] = PROD_BITS'(em[j]);
        end else begin
          mul_a[i][j] = PROD_BITS'(path_scores[i]);
          mul_b[i][j] = PROD_BITS'(trans_rows[i][j*PROB_BITS +: PROB_BITS]);
        end
      end
    end
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      for (int i = 0; i < NUM_STATES; i++) begin
        for (int j = 0; j < NUM_STATES; j++) begin
          prod[i][j] <= mul_a[i][j] * mul_b[i][j];
        end
      end
    end
  end

  // Best predecessor per state on the truncated products; ties keep the lower index.
  always_comb begin
    for (int j = 0; j < NUM_STATES; j++) begin
      top[j] = prod[0][j][PROB_BITS +: SCORE_BITS];
      arg[j] = '0;
      for (int i = 1; i < NUM_STATES; i++) begin
        if (prod[i][j][PROB_BITS +: SCORE_BITS] > top[j]) begin
          top[j] = prod[i][j][PROB_BITS +: SCORE_BITS];
          arg[j] = STATE_W'(i);
        end
      end
    end
  end

  // Emission stage.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      for (int j = 0; j < NUM_STATES; j++) begin
        if (first_q) begin
          eprod[j] <= prod[0][j];
          back[j]  <= '0;
        end else begin
          eprod[j] <= PROD_BITS'(top[j]) * PROD_BITS'(em[j]);
          back[j]  <= arg[j];
        end
      end
    end
  end

  // New scores and the best state among them.
  always_comb begin
    for (int j = 0; j < NUM_STATES; j++) begin
      if (first_q) begin
        new_score[j] = SCORE_BITS'((eprod[j] >> FIRST_SHR) << FIRST_SHL);
      end else begin
        new_score[j] = eprod[j][PROB_BITS +: SCORE_BITS];
      end
    end
    best_val = new_score[0];
    best_idx = '0;
    for (int j = 1; j < NUM_STATES; j++) begin
      if (new_score[j] > best_val) begin
        best_val = new_score[j];
        best_idx = STATE_W'(j);
      end
    end
  end

  // Commit the scores and load the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      path_scores <= '0;
    end else if (cmd.fin) begin
      path_scores <= new_score;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_data.best_state   <= best_idx;
      out_data.best_score   <= OUT_SCORE_BITS'(best_val);
      out_data.back_from_s0 <= back[0];
      out_data.back_from_s1 <= back[1];
      out_data.back_from_s2 <= back[2];
    end
  end

endmodule

>>> sv/hmm_viterbi_step.sv
// ----------------------------------------------------------------------------
// hmm_viterbi_step
// Viterbi recursion step for a 3-state, 3-symbol hidden Markov model.
// ----------------------------------------------------------------------------
// One observation beat in, one result beat out. The accepted beat passes a
// product stage, an emission stage and a commit stage. The product stage forms
// nine score-times-transition products, or initial times emission on a
// sequence start. The emission stage picks each state's best predecessor and
// scales it by the emission probability; on a sequence start it passes the
// initial product through. The commit stage updates the path scores, selects
// the best state and loads the result register. A new beat is accepted only
// once the commit is done. A result waiting on the output holds the commit
// stage, so a following item can be accepted but then waits in that stage.
// Configuration registers are written through a plain write port; the user
// must write them only while idle, as the block itself does not enforce it.
module hmm_viterbi_step
  import hmmv_pkg::*;
#(
  parameter int PROB_BITS  = 16,
  parameter int SCORE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  hmmv_in_t                in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output hmmv_out_t               out_data,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  hmmv_cmd_t cmd;

  // Sequencer.
  hmmv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Arithmetic and storage.
  hmmv_datapath #(
    .PROB_BITS  (PROB_BITS),
    .SCORE_BITS (SCORE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

>>> sv/hmmv_assert_chk.sv
// ----------------------------------------------------------------------------
// hmmv_assert_chk
// Port-level checks of the Viterbi step block, bound to the top level.
// ----------------------------------------------------------------------------
`include "hmm_viterbi_step_assert.svh"

module hmmv_assert_chk
  import hmmv_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input hmmv_out_t out_data
);

  // A stalled result beat holds its payload.
  `HMMV_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

  // One item at a time: the input closes right after a beat is taken.
  `HMMV_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  // The best state is always a real state.
  `HMMV_ASSERT_SAME(a_best_range, clk, rst, out_valid, out_data.best_state != 2'd3)

  // Backpointers name real states.
  `HMMV_ASSERT_SAME(a_back_range, clk, rst, out_valid,
    out_data.back_from_s0 != 2'd3 && out_data.back_from_s1 != 2'd3 &&
    out_data.back_from_s2 != 2'd3)

endmodule

bind hmm_viterbi_step hmmv_assert_chk u_assert_chk (.*);

>>> sim/hmm_viterbi_step_tb.sv
// ----------------------------------------------------------------------------
// hmm_viterbi_step_tb
// Self-checking bench for the 3-state HMM Viterbi step block.
// ----------------------------------------------------------------------------
// The bench loads the probability registers and streams observation beats
// through the valid/ready input. It models the path scores itself and checks
// each result beat field by field. A short directed table covers reset values,
// the extreme settings and the meaningless fourth symbol. Random phases follow,
// each with its own random setting. Sender and receiver insert random gaps,
// and one phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module hmm_viterbi_step_tb;
  import hmmv_pkg::*;

  localparam int PROB_W       = 16;
  localparam int SCORE_W      = OUT_SCORE_BITS;
  localparam int NUM_REGS     = REG_EMIT2 + 1;
  localparam int MAX_REPORTS  = 10;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_BEATS  = 130;
  localparam int CHOKE_PHASE  = 2;
  localparam int PAUSE_PHASE  = 6;
  localparam int CHOKE_CYCLES = 300;
  localparam int DRAIN_SLACK  = 8;
  localparam int LIMIT_CYCLES = 400000;

  // Index past the register file; writes to it must be ignored.
  localparam logic [CFG_IDX_BITS-1:0] REG_PAST_END = 3'd7;

  typedef enum logic [1:0] {SET_ZERO, SET_FULL, SET_MIXED} setting_t;
  typedef enum int {STYLE_ANY, STYLE_HIGH, STYLE_COARSE, STYLE_LOW} prob_style_t;

  typedef struct packed {
    setting_t           setting;
    logic [1:0]         observation;
    logic               first_of_sequence;
    logic               typed;
    state_idx_t         best_state;
    logic [SCORE_W-1:0] best_score;
  } dir_row_t;

  // Typed rows all carry zero backpointers: each is a sequence start or follows
  // all-zero path scores.
  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{SET_ZERO,  SYM_UP,   1'b0, 1'b1, 2'd0, 32'h0000_0000},
    '{SET_ZERO,  SYM_NONE, 1'b0, 1'b1, 2'd0, 32'h0000_0000},
    '{SET_ZERO,  SYM_FLAT, 1'b1, 1'b1, 2'd0, 32'h0000_0000},
    '{SET_FULL,  SYM_UP,   1'b1, 1'b1, 2'd0, 32'hFFFE_0001},
    '{SET_FULL,  SYM_DOWN, 1'b0, 1'b0, 2'd0, 32'h0000_0000},
    '{SET_FULL,  SYM_FLAT, 1'b0, 1'b0, 2'd0, 32'h0000_0000},
    '{SET_FULL,  SYM_NONE, 1'b1, 1'b1, 2'd0, 32'h0000_0000},
    '{SET_FULL,  SYM_DOWN, 1'b0, 1'b1, 2'd0, 32'h0000_0000},
    '{SET_FULL,  SYM_FLAT, 1'b1, 1'b1, 2'd0, 32'hFFFE_0001},
    '{SET_FULL,  SYM_NONE, 1'b0, 1'b0, 2'd0, 32'h0000_0000},
    '{SET_MIXED, SYM_UP,   1'b1, 1'b0, 2'd0, 32'h0000_0000},
    '{SET_MIXED, SYM_DOWN, 1'b0, 1'b0, 2'd0, 32'h0000_0000},
    '{SET_MIXED, SYM_FLAT, 1'b0, 1'b0, 2'd0, 32'h0000_0000},
    '{SET_MIXED, SYM_UP,   1'b0, 1'b0, 2'd0, 32'h0000_0000},
    '{SET_MIXED, SYM_NONE, 1'b0, 1'b0, 2'd0, 32'h0000_0000},
    '{SET_MIXED, SYM_DOWN, 1'b1, 1'b0, 2'd0, 32'h0000_0000},
    '{SET_MIXED, SYM_DOWN, 1'b0, 1'b0, 2'd0, 32'h0000_0000},
    '{SET_MIXED, SYM_FLAT, 1'b0, 1'b0, 2'd0, 32'h0000_0000},
    '{SET_MIXED, SYM_UP,   1'b1, 1'b0, 2'd0, 32'h0000_0000},
    '{SET_MIXED, SYM_FLAT, 1'b0, 1'b0, 2'd0, 32'h0000_0000},
    '{SET_MIXED, SYM_DOWN, 1'b0, 1'b0, 2'd0, 32'h0000_0000},
    '{SET_ZERO,  SYM_UP,   1'b1, 1'b1, 2'd0, 32'h0000_0000},
    '{SET_ZERO,  SYM_DOWN, 1'b0, 1'b1, 2'd0, 32'h0000_0000}
  };

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  hmmv_in_t                in_data;
  logic                    out_valid;
  logic                    out_ready;
  hmmv_out_t               out_data;
  logic                    cfg_wr_en;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;

  // Bench copy of the registers and the path scores.
  logic [CFG_BITS-1:0] prob_reg   [NUM_REGS];
  logic [CFG_BITS-1:0] cfg_plan   [NUM_REGS];
  logic [SCORE_W-1:0]  path_score [NUM_STATES];
  hmmv_out_t           pending_results [$];

  bit tx_steady;
  bit rx_steady;
  bit choke_req;
  int mismatch_count;
  int beats_in;
  int seq_starts;
  int results_seen;
  int zero_scores;
  int settings_loaded;
  int input_stalls;
  int cycle_count;

  hmm_viterbi_step i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Element k of a packed probability register.
  function automatic logic [PROB_W-1:0] prob_at(input logic [CFG_BITS-1:0] r, input int k);
    return r[PROB_W*k +: PROB_W];
  endfunction

  // Score times probability, low fraction bits dropped.
  function automatic logic [SCORE_W-1:0] scale_by(input logic [SCORE_W-1:0] score,
                                                  input logic [PROB_W-1:0] prob);
    logic [SCORE_W+PROB_W-1:0] prod;
    prod = {{PROB_W{1'b0}}, score} * {{SCORE_W{1'b0}}, prob};
    return prod[SCORE_W+PROB_W-1:PROB_W];
  endfunction

  // One Viterbi step on the bench's path scores; returns the result beat.
  function automatic hmmv_out_t advance_paths(input hmmv_in_t beat);
    logic [SCORE_W-1:0] nxt [NUM_STATES];
    state_idx_t         back [NUM_STATES];
    logic [SCORE_W-1:0] cand;
    logic [SCORE_W-1:0] top;
    logic [PROB_W-1:0]  em;
    logic [PROB_W-1:0]  init_p;
    hmmv_out_t          res;
    for (int j = 0; j < NUM_STATES; j++) begin
      em = (beat.observation == SYM_NONE) ? '0 :
           prob_at(prob_reg[REG_EMIT0 + j], beat.observation);
      back[j] = '0;
      if (beat.first_of_sequence) begin
        init_p = prob_at(prob_reg[REG_INITIAL], j);
        nxt[j] = {{PROB_W{1'b0}}, init_p} * {{PROB_W{1'b0}}, em};
      end else begin
        top = '0;
        for (int i = 0; i < NUM_STATES; i++) begin
          cand = scale_by(path_score[i], prob_at(prob_reg[REG_TRANS0 + i], j));
          // Strictly greater keeps the lowest index on ties.
          if (i == 0 || cand > top) begin
            top = cand;
            back[j] = state_idx_t'(i);
          end
        end
        nxt[j] = scale_by(top, em);
      end
    end
    res = '0;
    for (int j = 1; j < NUM_STATES; j++) begin
      if (nxt[j] > nxt[res.best_state]) begin
        res.best_state = state_idx_t'(j);
      end
    end
    res.best_score   = nxt[res.best_state];
    res.back_from_s0 = back[0];
    res.back_from_s1 = back[1];
    res.back_from_s2 = back[2];
    for (int j = 0; j < NUM_STATES; j++) begin
      path_score[j] = nxt[j];
    end
    return res;
  endfunction

  function automatic logic [PROB_W-1:0] rand_prob(input prob_style_t style);
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    case (style)
      STYLE_HIGH: return PROB_W'($urandom_range(16'hC000, 16'hFFFF));
      STYLE_COARSE: begin
        // Coarse values make equal candidates, so ties get exercised.
        case ($urandom_range(0, 3))
          0: return 16'h2000;
          1: return 16'h4000;
          2: return 16'h8000;
          default: return 16'hC000;
        endcase
      end
      STYLE_LOW: return PROB_W'($urandom_range(0, 16'h00FF));
      default: return PROB_W'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] rand_symbol();
    if ($urandom_range(0, 31) == 0) return SYM_NONE;
    case ($urandom_range(0, 2))
      0: return SYM_UP;
      1: return SYM_DOWN;
      default: return SYM_FLAT;
    endcase
  endfunction

  function automatic int tx_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("Mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
    end
  endtask

  task automatic plan_fixed(input setting_t s);
    case (s)
      SET_FULL: begin
        foreach (cfg_plan[r]) cfg_plan[r] = '1;
      end
      SET_MIXED: begin
        cfg_plan[REG_INITIAL] = {16'h4000, 16'h4000, 16'h8000};
        cfg_plan[REG_TRANS0]  = {16'h4000, 16'h4000, 16'h8000};
        cfg_plan[REG_TRANS1]  = {16'h4000, 16'h8000, 16'h4000};
        cfg_plan[REG_TRANS2]  = {16'hC000, 16'h2000, 16'h2000};
        cfg_plan[REG_EMIT0]   = {16'h2000, 16'h2000, 16'hC000};
        cfg_plan[REG_EMIT1]   = {16'h2000, 16'hC000, 16'h2000};
        cfg_plan[REG_EMIT2]   = {16'h8000, 16'h4000, 16'h4000};
      end
      default: begin
        foreach (cfg_plan[r]) cfg_plan[r] = '0;
      end
    endcase
  endtask

  task automatic plan_random(input prob_style_t style);
    foreach (cfg_plan[r]) begin
      cfg_plan[r] = {rand_prob(style), rand_prob(style), rand_prob(style)};
    end
  endtask

  // Write the planned registers, then a junk write past the last register.
  // Called at a falling edge with the block idle.
  task automatic load_plan();
    for (int i = REG_INITIAL; i <= REG_EMIT2; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_BITS'(i);
      cfg_data  <= cfg_plan[i];
      prob_reg[i] = cfg_plan[i];
      @(negedge clk);
    end
    cfg_index <= REG_PAST_END;
    cfg_data  <= CFG_BITS'({$urandom, $urandom});
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_loaded++;
  endtask

  // Stop offering and wait until every expected result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  // Offer one beat after a random gap; on acceptance, store its expected result.
  task automatic offer(input hmmv_in_t beat, input bit typed, input hmmv_out_t want);
    int        gap;
    hmmv_out_t predicted;
    gap = tx_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_paths(beat);
    pending_results.push_back(typed ? want : predicted);
    beats_in++;
    if (beat.first_of_sequence) seq_starts++;
    @(negedge clk);
  endtask

  // Receiver: random hold-offs, plus one long choke on request.
  initial begin
    int hold;
    int r;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (hold != 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (choke_req) begin
        choke_req = 1'b0;
        hold = CHOKE_CYCLES;
        out_ready <= 1'b0;
      end else if (rx_steady || r < 65) begin
        out_ready <= 1'b1;
      end else begin
        hold = (r < 92) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        out_ready <= 1'b0;
      end
    end
  end

  // Check each result beat against the oldest expectation.
  always @(posedge clk) begin : check_results
    hmmv_out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (out_data.best_score == '0) zero_scores++;
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending, best_score", 0, out_data.best_score);
      end else begin
        want = pending_results.pop_front();
        if (out_data.best_state !== want.best_state)
          flag_mismatch("best_state", want.best_state, out_data.best_state);
        if (out_data.best_score !== want.best_score)
          flag_mismatch("best_score", want.best_score, out_data.best_score);
        if (out_data.back_from_s0 !== want.back_from_s0)
          flag_mismatch("back_from_s0", want.back_from_s0, out_data.back_from_s0);
        if (out_data.back_from_s1 !== want.back_from_s1)
          flag_mismatch("back_from_s1", want.back_from_s1, out_data.back_from_s1);
        if (out_data.back_from_s2 !== want.back_from_s2)
          flag_mismatch("back_from_s2", want.back_from_s2, out_data.back_from_s2);
      end
    end
  end

  // Watchdog and input stall count.
  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && !in_ready) input_stalls++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d results pending",
               cycle_count, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    setting_t  cur_setting;
    hmmv_in_t  beat;
    hmmv_out_t want;
    int        sent;
    int        run_len;
    bit        paused;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_INITIAL;
    cfg_data  = '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    choke_req = 1'b0;
    foreach (prob_reg[r]) prob_reg[r] = '0;
    foreach (path_score[s]) path_score[s] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table; a change of setting drains the block and reloads it.
    cur_setting = SET_ZERO;
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].setting != cur_setting) begin
        wait_drained();
        cur_setting = DIR_TABLE[r].setting;
        plan_fixed(cur_setting);
        load_plan();
      end
      beat.observation       = DIR_TABLE[r].observation;
      beat.first_of_sequence = DIR_TABLE[r].first_of_sequence;
      want = '0;
      want.best_state = DIR_TABLE[r].best_state;
      want.best_score = DIR_TABLE[r].best_score;
      offer(beat, DIR_TABLE[r].typed, want);
    end

    // Random phases: mostly well-formed runs starting with a sequence start,
    // with some stray beats mixed in.
    want = '0;
    for (int round_idx = 0; round_idx < RAND_PHASES; round_idx++) begin
      wait_drained();
      plan_random(prob_style_t'(round_idx % 4));
      load_plan();
      tx_steady = (round_idx == CHOKE_PHASE) || (round_idx == 3);
      rx_steady = (round_idx == 5);
      if (round_idx == CHOKE_PHASE) choke_req = 1'b1;
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_BEATS) begin
        if (round_idx == PAUSE_PHASE && !paused && sent >= PHASE_BEATS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) begin
          beat.observation       = rand_symbol();
          beat.first_of_sequence = 1'($urandom_range(0, 1));
          offer(beat, 1'b0, want);
          sent++;
        end else begin
          run_len = $urandom_range(1, 24);
          if (run_len > PHASE_BEATS - sent) run_len = PHASE_BEATS - sent;
          for (int k = 0; k < run_len; k++) begin
            beat.observation       = rand_symbol();
            beat.first_of_sequence = (k == 0);
            offer(beat, 1'b0, want);
            sent++;
          end
        end
      end
    end

    wait_drained();
    $display("Run covered %0d beats (%0d sequence starts) over %0d register settings.",
             beats_in, seq_starts, settings_loaded);
    $display("Checked %0d results, %0d with zero score; input stalled %0d cycles.",
             results_seen, zero_scores, input_stalls);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/hmmv_pkg.sv
sv/hmmv_ctrl.sv
sv/hmmv_datapath.sv
sv/hmm_viterbi_step.sv
sv/hmmv_assert_chk.sv
sim/hmm_viterbi_step_tb.sv
